@@ src/assertion_attempt_tracker_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the attempt tracker
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERTION_ATTEMPT_TRACKER_UNIT_ASSERT_SVH
`define ASSERTION_ATTEMPT_TRACKER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define AAT_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("attempt tracker assertion failed");
`define AAT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("attempt tracker forbidden condition");
`else
`define AAT_ASSERT(label, prop)
`define AAT_NEVER(label, expr)
`endif
`endif

@@ src/aat_pkg.sv @@
// ----------------------------------------------------------------------------
// aat_pkg
// Sizes, codes and word types of the assertion attempt tracker.
// ----------------------------------------------------------------------------
`default_nettype none
package aat_pkg;

  localparam int MAX_EVALS    = 16;
  localparam int MAX_ATTEMPTS = 8;
  localparam int MAX_WORDS    = 4;
  localparam int SEED_REGS    = 4;

  localparam int EV_W   = $clog2(MAX_EVALS);
  localparam int EC_W   = EV_W + 1;
  localparam int AT_W   = $clog2(MAX_ATTEMPTS);
  localparam int AC_W   = AT_W + 1;
  localparam int WD_W   = $clog2(MAX_WORDS);
  localparam int ADDR_W = EV_W + WD_W;
  localparam int DEPTH  = MAX_EVALS * MAX_WORDS;

  // command modes
  localparam logic [3:0] MODE_BEGIN   = 4'd0;
  localparam logic [3:0] MODE_DISABLE = 4'd1;
  localparam logic [3:0] MODE_LIVE    = 4'd2;
  localparam logic [3:0] MODE_NEXT    = 4'd3;
  localparam logic [3:0] MODE_READ    = 4'd4;
  localparam logic [3:0] MODE_WRITE   = 4'd5;
  localparam logic [3:0] MODE_STEP    = 4'd6;
  localparam logic [3:0] MODE_FORK    = 4'd7;
  localparam logic [3:0] MODE_SETTLE  = 4'd8;
  localparam logic [3:0] MODE_ENDRUN  = 4'd9;

  // outcomes
  localparam logic [1:0] OUT_LIVE   = 2'd0;
  localparam logic [1:0] OUT_FAILED = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_DONE = 2'd0;
  localparam logic [1:0] KIND_PASS = 2'd1;
  localparam logic [1:0] KIND_FAIL = 2'd2;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_IDX  = 3'd1;
  localparam logic [2:0] ST_BAD_WORD = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd4;

  // configuration register indexes
  localparam logic [2:0] CFG_WORDS   = 3'd0;
  localparam logic [2:0] CFG_PENDING = 3'd1;
  localparam logic [2:0] CFG_SEED0   = 3'd2;
  localparam logic [2:0] CFG_SEED3   = 3'd5;

  typedef struct packed {
    logic [3:0]  mode;
    logic [3:0]  eval_index;
    logic [1:0]  word_index;
    logic [63:0] word_bits;
    logic [1:0]  outcome;
    logic        tick_now;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [63:0] value;
    logic        none_left;
    logic        last;
  } out_word_t;

endpackage
`default_nettype wire

@@ src/aat_ram.sv @@
// ----------------------------------------------------------------------------
// aat_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module aat_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ src/assertion_attempt_tracker_unit.sv @@
// Begin and fork fill a new row with seed words; liveword reads the row of
// each evaluation; next-unstepped skips stepped slots; settle walks the
// attempts, then the evaluations, copying each kept row; endrun walks the
// attempts. One command at a time, input held off.
// Reset clears counts, cursor and config; tables need no clearing pass.
// ----------------------------------------------------------------------------
// assertion_attempt_tracker_unit
// Sequencer over flop tables and a position-word RAM that tracks attempts.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assertion_attempt_tracker_unit_assert.svh"
module assertion_attempt_tracker_unit
  import aat_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_word_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_word_t        out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_data_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_SEED  = 4'd2;
  localparam logic [3:0] S_LWRD  = 4'd3;
  localparam logic [3:0] S_LWAC  = 4'd4;
  localparam logic [3:0] S_NU    = 4'd5;
  localparam logic [3:0] S_RDW   = 4'd6;
  localparam logic [3:0] S_REPLY = 4'd7;
  localparam logic [3:0] S_SCNT  = 4'd8;
  localparam logic [3:0] S_SATT  = 4'd9;
  localparam logic [3:0] S_SEV   = 4'd10;
  localparam logic [3:0] S_CPRD  = 4'd11;
  localparam logic [3:0] S_CPWR  = 4'd12;
  localparam logic [3:0] S_SFIN  = 4'd13;
  localparam logic [3:0] S_ERUN  = 4'd14;

  // control state
  logic [3:0]      state_q, state_d;
  logic [EC_W-1:0] ec_q, ec_d, cur_q, cur_d, ecnt_q, ecnt_d, ke_q, ke_d;
  logic [AC_W-1:0] ac_q, ac_d, acnt_q, acnt_d, ka_q, ka_d;
  logic [WD_W-1:0] wcnt_q, wcnt_d;
  logic [2:0]      wiu_q, wiu_d;
  logic            pcp_q, pcp_d;
  logic            out_vld_q, out_vld_d;

  // payload state
  logic [63:0]     seed_q [SEED_REGS];
  logic [63:0]     seed_d [SEED_REGS];
  in_word_t        cmd_q, cmd_d;
  out_word_t       out_q, out_d;
  logic [2:0]      rep_st_q, rep_st_d;
  logic [63:0]     rep_val_q, rep_val_d;
  logic            rep_none_q, rep_none_d;
  logic [AT_W-1:0] owner_q [MAX_EVALS];
  logic [AT_W-1:0] owner_d [MAX_EVALS];
  logic [MAX_EVALS-1:0]    stepped_q, stepped_d, live_q, live_d;
  logic [MAX_ATTEMPTS-1:0] failed_q, failed_d, keep_q, keep_d, hasl_q, hasl_d;
  logic [AT_W-1:0] renum_q [MAX_ATTEMPTS];
  logic [AT_W-1:0] renum_d [MAX_ATTEMPTS];

  // RAM port signals
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [63:0]       ram_wdata, ram_rdata;

  logic [2:0]      wid;
  logic            out_free, push;
  out_word_t       push_w;
  logic            idx_bad, word_bad;
  logic [EV_W-1:0] ci, ce, ne;
  logic [AT_W-1:0] ca, eo;

  aat_ram #(
    .Width (64),
    .Depth (DEPTH)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // clamp the width register
  always_comb begin
    if (wiu_q == 3'd0) begin
      wid = 3'd1;
    end else if ({1'b0, wiu_q} > 4'(MAX_WORDS)) begin
      wid = 3'(MAX_WORDS);
    end else begin
      wid = wiu_q;
    end
  end

  assign out_free    = !out_vld_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign idx_bad     = {1'b0, cmd_q.eval_index} >= ec_q;
  assign word_bad    = {1'b0, cmd_q.word_index} >= wid;
  assign ci          = cmd_q.eval_index;
  assign ce          = ecnt_q[EV_W-1:0];
  assign ne          = ec_q[EV_W-1:0];
  assign ca          = acnt_q[AT_W-1:0];
  assign eo          = owner_q[ce];

  // sequencer
  always_comb begin
    state_d    = state_q;
    ec_d       = ec_q;
    cur_d      = cur_q;
    ecnt_d     = ecnt_q;
    ke_d       = ke_q;
    ac_d       = ac_q;
    acnt_d     = acnt_q;
    ka_d       = ka_q;
    wcnt_d     = wcnt_q;
    wiu_d      = wiu_q;
    pcp_d      = pcp_q;
    seed_d     = seed_q;
    cmd_d      = cmd_q;
    rep_st_d   = rep_st_q;
    rep_val_d  = rep_val_q;
    rep_none_d = rep_none_q;
    owner_d    = owner_q;
    stepped_d  = stepped_q;
    live_d     = live_q;
    failed_d   = failed_q;
    keep_d     = keep_q;
    hasl_d     = hasl_q;
    renum_d    = renum_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = {ne, wcnt_q};
    ram_raddr  = {ci, cmd_q.word_index};
    ram_wdata  = seed_q[wcnt_q];
    push       = 1'b0;
    push_w     = '0;

    // configuration writes
    if (cfg_we_i) begin
      if (cfg_idx_i == CFG_WORDS) begin
        wiu_d = cfg_data_i[2:0];
      end else if (cfg_idx_i == CFG_PENDING) begin
        pcp_d = cfg_data_i[0];
      end else if (cfg_idx_i >= CFG_SEED0 && cfg_idx_i <= CFG_SEED3) begin
        seed_d[2'(cfg_idx_i - CFG_SEED0)] = cfg_data_i;
      end
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = in_data_i;
          state_d = S_DISP;
        end
      end

      S_DISP: begin
        rep_st_d   = ST_OK;
        rep_val_d  = '0;
        rep_none_d = 1'b0;
        wcnt_d     = '0;
        ecnt_d     = '0;
        acnt_d     = '0;
        state_d    = S_REPLY;
        case (cmd_q.mode)
          MODE_BEGIN: begin
            if (ac_q == AC_W'(MAX_ATTEMPTS) || ec_q == EC_W'(MAX_EVALS)) begin
              rep_st_d = ST_FULL;
            end else begin
              stepped_d                 = '0;
              failed_d[ac_q[AT_W-1:0]]  = 1'b0;
              owner_d[ne]               = ac_q[AT_W-1:0];
              live_d[ne]                = 1'b1;
              ac_d                      = ac_q + 1'b1;
              state_d                   = S_SEED;
            end
          end
          MODE_DISABLE: begin
            ec_d  = '0;
            ac_d  = '0;
            cur_d = '0;
          end
          MODE_LIVE: begin
            if (word_bad) begin
              rep_st_d = ST_BAD_WORD;
            end else if (ec_q != '0) begin
              state_d = S_LWRD;
            end
          end
          MODE_NEXT: begin
            state_d = S_NU;
          end
          MODE_READ: begin
            if (idx_bad) begin
              rep_st_d = ST_BAD_IDX;
            end else if (word_bad) begin
              rep_st_d = ST_BAD_WORD;
            end else begin
              ram_re  = 1'b1;
              state_d = S_RDW;
            end
          end
          MODE_WRITE: begin
            if (idx_bad) begin
              rep_st_d = ST_BAD_IDX;
            end else if (word_bad) begin
              rep_st_d = ST_BAD_WORD;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = {ci, cmd_q.word_index};
              ram_wdata = cmd_q.word_bits;
            end
          end
          MODE_STEP: begin
            if (idx_bad) begin
              rep_st_d = ST_BAD_IDX;
            end else begin
              stepped_d[ci] = 1'b1;
              if (cmd_q.outcome != OUT_LIVE) begin
                live_d[ci] = 1'b0;
              end
              if (cmd_q.outcome == OUT_FAILED) begin
                failed_d[owner_q[ci]] = 1'b1;
              end
            end
          end
          MODE_FORK: begin
            if (idx_bad) begin
              rep_st_d = ST_BAD_IDX;
            end else if (ec_q == EC_W'(MAX_EVALS)) begin
              rep_st_d = ST_FULL;
            end else begin
              owner_d[ne]   = owner_q[ci];
              stepped_d[ne] = !cmd_q.tick_now;
              live_d[ne]    = 1'b1;
              state_d       = S_SEED;
            end
          end
          MODE_SETTLE: begin
            state_d = S_SCNT;
          end
          MODE_ENDRUN: begin
            state_d = S_ERUN;
          end
          default: begin
            state_d = S_REPLY;
          end
        endcase
      end

      // fill the new row with seed words
      S_SEED: begin
        ram_we = 1'b1;
        wcnt_d = wcnt_q + 1'b1;
        if (wcnt_q == WD_W'(MAX_WORDS - 1)) begin
          ec_d = ec_q + 1'b1;
          if (cmd_q.mode == MODE_BEGIN) begin
            cur_d = '0;
          end
          state_d = S_REPLY;
        end
      end

      // liveword: read one row, then fold it in
      S_LWRD: begin
        ram_re    = 1'b1;
        ram_raddr = {ce, cmd_q.word_index};
        state_d   = S_LWAC;
      end

      S_LWAC: begin
        if (!stepped_q[ce]) begin
          rep_val_d = rep_val_q | ram_rdata;
        end
        ecnt_d  = ecnt_q + 1'b1;
        state_d = (ecnt_q + 1'b1 == ec_q) ? S_REPLY : S_LWRD;
      end

      // advance the cursor past stepped slots
      S_NU: begin
        if (cur_q < ec_q && stepped_q[cur_q[EV_W-1:0]]) begin
          cur_d = cur_q + 1'b1;
        end else begin
          if (cur_q >= ec_q) begin
            rep_none_d = 1'b1;
          end else begin
            rep_val_d = 64'(cur_q);
          end
          state_d = S_REPLY;
        end
      end

      S_RDW: begin
        rep_val_d = ram_rdata;
        state_d   = S_REPLY;
      end

      S_REPLY: begin
        if (out_free) begin
          push             = 1'b1;
          push_w.kind      = KIND_DONE;
          push_w.status    = rep_st_q;
          push_w.value     = rep_val_q;
          push_w.none_left = rep_none_q;
          push_w.last      = 1'b1;
          state_d          = S_IDLE;
        end
      end

      // settle: mark attempts that still own a live evaluation
      S_SCNT: begin
        for (int a = 0; a < MAX_ATTEMPTS; a++) begin
          hasl_d[a] = 1'b0;
          for (int e = 0; e < MAX_EVALS; e++) begin
            if (EC_W'(e) < ec_q && live_q[e] && owner_q[e] == AT_W'(a)) begin
              hasl_d[a] = 1'b1;
            end
          end
        end
        keep_d  = '0;
        ka_d    = '0;
        state_d = S_SATT;
      end

      // settle: answer or keep one attempt a cycle, answers waiting on a free output
      S_SATT: begin
        if (acnt_q < ac_q) begin
          if (failed_q[ca] || !hasl_q[ca]) begin
            if (out_free) begin
              push        = 1'b1;
              push_w.kind = failed_q[ca] ? KIND_FAIL : KIND_PASS;
              acnt_d      = acnt_q + 1'b1;
            end
          end else begin
            keep_d[ca]                = 1'b1;
            renum_d[ca]               = ka_q[AT_W-1:0];
            failed_d[ka_q[AT_W-1:0]]  = 1'b0;
            ka_d                      = ka_q + 1'b1;
            acnt_d                    = acnt_q + 1'b1;
          end
        end else begin
          ecnt_d  = '0;
          ke_d    = '0;
          state_d = S_SEV;
        end
      end

      // settle: compact surviving evaluations
      S_SEV: begin
        if (ecnt_q < ec_q) begin
          if (live_q[ce] && keep_q[eo]) begin
            owner_d[ke_q[EV_W-1:0]]   = renum_q[eo];
            stepped_d[ke_q[EV_W-1:0]] = stepped_q[ce];
            live_d[ke_q[EV_W-1:0]]    = 1'b1;
            wcnt_d                    = '0;
            state_d                   = S_CPRD;
          end else begin
            ecnt_d = ecnt_q + 1'b1;
          end
        end else begin
          state_d = S_SFIN;
        end
      end

      S_CPRD: begin
        ram_re    = 1'b1;
        ram_raddr = {ce, wcnt_q};
        state_d   = S_CPWR;
      end

      S_CPWR: begin
        ram_we    = 1'b1;
        ram_waddr = {ke_q[EV_W-1:0], wcnt_q};
        ram_wdata = ram_rdata;
        wcnt_d    = wcnt_q + 1'b1;
        if (wcnt_q == WD_W'(MAX_WORDS - 1)) begin
          ke_d    = ke_q + 1'b1;
          ecnt_d  = ecnt_q + 1'b1;
          state_d = S_SEV;
        end else begin
          state_d = S_CPRD;
        end
      end

      S_SFIN: begin
        ac_d    = ka_q;
        ec_d    = ke_q;
        cur_d   = '0;
        state_d = S_REPLY;
      end

      // end of run: pass pending attempts if so configured, then drop all
      S_ERUN: begin
        if (pcp_q && acnt_q < ac_q) begin
          if (out_free) begin
            push        = 1'b1;
            push_w.kind = KIND_PASS;
            acnt_d      = acnt_q + 1'b1;
          end
        end else begin
          ec_d    = '0;
          ac_d    = '0;
          cur_d   = '0;
          state_d = S_REPLY;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_vld_d = out_vld_q && out_stall_i;
    out_d     = out_q;
    if (push) begin
      out_vld_d = 1'b1;
      out_d     = push_w;
    end
  end

  // hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ec_q      <= '0;
      ac_q      <= '0;
      cur_q     <= '0;
      ecnt_q    <= '0;
      ke_q      <= '0;
      acnt_q    <= '0;
      ka_q      <= '0;
      wcnt_q    <= '0;
      wiu_q     <= 3'd1;
      pcp_q     <= 1'b0;
      out_vld_q <= 1'b0;
      seed_q    <= '{default: '0};
    end else begin
      state_q   <= state_d;
      ec_q      <= ec_d;
      ac_q      <= ac_d;
      cur_q     <= cur_d;
      ecnt_q    <= ecnt_d;
      ke_q      <= ke_d;
      acnt_q    <= acnt_d;
      ka_q      <= ka_d;
      wcnt_q    <= wcnt_d;
      wiu_q     <= wiu_d;
      pcp_q     <= pcp_d;
      out_vld_q <= out_vld_d;
      seed_q    <= seed_d;
    end
  end

  // hold tables and payload
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    out_q      <= out_d;
    rep_st_q   <= rep_st_d;
    rep_val_q  <= rep_val_d;
    rep_none_q <= rep_none_d;
    owner_q    <= owner_d;
    stepped_q  <= stepped_d;
    live_q     <= live_d;
    failed_q   <= failed_d;
    keep_q     <= keep_d;
    hasl_q     <= hasl_d;
    renum_q    <= renum_d;
  end

  `AAT_NEVER(a_ec_range, ec_q > EC_W'(MAX_EVALS))
  `AAT_NEVER(a_ac_range, ac_q > AC_W'(MAX_ATTEMPTS))
  `AAT_ASSERT(a_cur_bound, state_q == S_IDLE |-> cur_q <= ec_q)
  `AAT_ASSERT(a_last_idle, push && push_w.last |=> state_q == S_IDLE)
  `AAT_NEVER(a_kept_le, state_q == S_SEV && ke_q > ecnt_q)

endmodule
`default_nettype wire
